### sv/mcg_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mcg_pkg
// Shared types and constants of the midpoint circle generator.
// ---------------------------------------------------------------------------
package mcg_pkg;

    localparam int SCREEN_BITS  = 14;
    localparam int OCT_BITS     = 3;
    localparam int CFG_IDX_BITS = 2;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y = 2'd1;

    localparam int ORIGIN_X_RESET = 320;
    localparam int ORIGIN_Y_RESET = 240;

    localparam logic [OCT_BITS-1:0] OCT_LAST = 3'd7;

    // control part of one queued step job
    typedef struct packed {
        logic pixel;    // 0: step without an active circle
        logic done;     // circle finishes with this step
    } job_ctrl_t;

    localparam int JOB_CTRL_BITS = $bits(job_ctrl_t);

endpackage
`default_nettype wire

### sv/mcg_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mcg_front
// Command front end: holds the circle state, takes start and step commands
// and pushes one job per step into the queue.
// ---------------------------------------------------------------------------
module mcg_front #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         cmd_valid,
    output logic                        cmd_ready,
    input  wire                         cmd_kind,
    input  wire  [COORD_BITS-1:0]       cmd_center_x,
    input  wire  [COORD_BITS-1:0]       cmd_center_y,
    input  wire  [RADIUS_BITS-1:0]      cmd_radius,
    input  wire                         job_ready,
    output logic                        job_push,
    output mcg_pkg::job_ctrl_t          job_ctrl,
    output logic [RADIUS_BITS-1:0]      job_x,
    output logic [RADIUS_BITS-1:0]      job_y,
    output logic [COORD_BITS-1:0]       job_center_x,
    output logic [COORD_BITS-1:0]       job_center_y
);
    import mcg_pkg::*;

    localparam int N_BITS   = RADIUS_BITS + 2;
    localparam int DEC_BITS = RADIUS_BITS + 3;

    logic [RADIUS_BITS-1:0]     x_reg, x_next;
    logic [RADIUS_BITS-1:0]     y_reg, y_next;
    logic signed [DEC_BITS-1:0] dec_reg, dec_next;
    logic [COORD_BITS-1:0]      cx_reg, cx_next;
    logic [COORD_BITS-1:0]      cy_reg, cy_next;
    logic                       active_reg, active_next;

    logic                       accept;
    logic                       dec_pos;
    logic signed [N_BITS-1:0]   nx, ny, diff;
    logic                       done;

    assign cmd_ready = job_ready;
    assign accept    = cmd_valid && cmd_ready;

    always_comb begin
        dec_pos = !dec_reg[DEC_BITS-1] && (dec_reg != '0);
        nx      = N_BITS'({2'b00, x_reg}) + N_BITS'(1);
        ny      = N_BITS'({2'b00, y_reg}) - N_BITS'(dec_pos);
        diff    = dec_pos ? (nx - ny) : nx;
        done    = nx > ny;
    end

    always_comb begin
        x_next      = x_reg;
        y_next      = y_reg;
        dec_next    = dec_reg;
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        active_next = active_reg;
        if (accept) begin
            if (cmd_kind == CMD_START) begin
                x_next      = '0;
                y_next      = cmd_radius;
                dec_next    = DEC_BITS'(1) - DEC_BITS'(cmd_radius);
                cx_next     = cmd_center_x;
                cy_next     = cmd_center_y;
                active_next = 1'b1;
            end else if (active_reg) begin
                if (done) begin
                    x_next      = '0;
                    y_next      = '0;
                    dec_next    = '0;
                    active_next = 1'b0;
                end else begin
                    x_next   = nx[RADIUS_BITS-1:0];
                    y_next   = ny[RADIUS_BITS-1:0];
                    dec_next = dec_reg + (DEC_BITS'(diff) <<< 1) + DEC_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg      <= '0;
            y_reg      <= '0;
            dec_reg    <= '0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            active_reg <= 1'b0;
        end else begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            dec_reg    <= dec_next;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            active_reg <= active_next;
        end
    end

    // a step always queues a job; points use the state before the update
    assign job_push      = accept && (cmd_kind == CMD_STEP);
    assign job_ctrl.pixel = active_reg;
    assign job_ctrl.done  = active_reg && done;
    assign job_x         = x_reg;
    assign job_y         = y_reg;
    assign job_center_x  = cx_reg;
    assign job_center_y  = cy_reg;

endmodule
`default_nettype wire

### sv/mcg_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mcg_queue
// Two-entry job queue between the command front end and the pixel back end.
// ---------------------------------------------------------------------------
module mcg_queue #(
    parameter int WIDTH = 40
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              push,
    input  wire  [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  wire              pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);
    import mcg_pkg::*;

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

### sv/mcg_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// mcg_back
// Pixel back end: expands a step job into its eight symmetric points (one
// word if no circle), one registered word per cycle while res_ready is high.
// ---------------------------------------------------------------------------
module mcg_back #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire  [COORD_BITS-1:0]            origin_x,
    input  wire  [COORD_BITS-1:0]            origin_y,
    input  wire                              job_valid,
    output logic                             job_pop,
    input  mcg_pkg::job_ctrl_t               job_ctrl,
    input  wire  [RADIUS_BITS-1:0]           job_x,
    input  wire  [RADIUS_BITS-1:0]           job_y,
    input  wire  [COORD_BITS-1:0]            job_center_x,
    input  wire  [COORD_BITS-1:0]            job_center_y,
    output logic                             res_valid,
    input  wire                              res_ready,
    output logic                             res_pixel,
    output logic [mcg_pkg::SCREEN_BITS-1:0]  res_screen_x,
    output logic [mcg_pkg::SCREEN_BITS-1:0]  res_screen_y,
    output logic [mcg_pkg::OCT_BITS-1:0]     res_octant,
    output logic                             res_last,
    output logic                             res_done
);
    import mcg_pkg::*;

    logic                           busy_reg, busy_next;
    logic [OCT_BITS-1:0]            oct_reg, oct_next;
    job_ctrl_t                      ctrl_reg;
    logic [RADIUS_BITS-1:0]         x_reg, y_reg;
    logic signed [COORD_BITS-1:0]   cx_reg, cy_reg;

    logic                           valid_reg, valid_next;
    logic                           pixel_reg;
    logic [SCREEN_BITS-1:0]         sx_reg, sy_reg;
    logic [OCT_BITS-1:0]            octo_reg;
    logic                           last_reg, done_reg;

    logic                           emit, emit_last, load;
    logic [SCREEN_BITS-1:0]         a, b, pt_x, pt_y;

    assign emit      = busy_reg && (!valid_reg || res_ready);
    assign emit_last = !ctrl_reg.pixel || (oct_reg == OCT_LAST);
    assign load      = job_valid && (!busy_reg || (emit && emit_last));
    assign job_pop   = load;

    // octant code: bit 2 swaps x and y, bit 1 negates a, bit 0 negates b
    always_comb begin
        a = oct_reg[2] ? SCREEN_BITS'(y_reg) : SCREEN_BITS'(x_reg);
        b = oct_reg[2] ? SCREEN_BITS'(x_reg) : SCREEN_BITS'(y_reg);
        if (oct_reg[1]) begin
            a = -a;
        end
        if (oct_reg[0]) begin
            b = -b;
        end
        pt_x = SCREEN_BITS'(origin_x) + SCREEN_BITS'(cx_reg) + a;
        pt_y = SCREEN_BITS'(origin_y) - SCREEN_BITS'(cy_reg) - b;
    end

    always_comb begin
        busy_next  = busy_reg;
        oct_next   = oct_reg;
        valid_next = valid_reg;
        if (res_ready) begin
            valid_next = 1'b0;
        end
        if (emit) begin
            valid_next = 1'b1;
            if (emit_last) begin
                busy_next = 1'b0;
            end else begin
                oct_next = oct_reg + OCT_BITS'(1);
            end
        end
        if (load) begin
            busy_next = 1'b1;
            oct_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            oct_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            oct_reg   <= oct_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ctrl_reg <= job_ctrl;
            x_reg    <= job_x;
            y_reg    <= job_y;
            cx_reg   <= job_center_x;
            cy_reg   <= job_center_y;
        end
        if (emit) begin
            pixel_reg <= ctrl_reg.pixel;
            last_reg  <= emit_last;
            if (ctrl_reg.pixel) begin
                sx_reg   <= pt_x;
                sy_reg   <= pt_y;
                octo_reg <= oct_reg;
                done_reg <= ctrl_reg.done;
            end else begin
                sx_reg   <= '0;
                sy_reg   <= '0;
                octo_reg <= '0;
                done_reg <= 1'b0;
            end
        end
    end

    assign res_valid    = valid_reg;
    assign res_pixel    = pixel_reg;
    assign res_screen_x = sx_reg;
    assign res_screen_y = sy_reg;
    assign res_octant   = octo_reg;
    assign res_last     = last_reg;
    assign res_done     = done_reg;

endmodule
`default_nettype wire

### sv/midpoint_circle_generator.sv
`default_nettype none
// A step word passes the job queue and the back end's job registers, and its
// first pixel leaves the back end's output register. Each step gives eight
// result words, one a cycle from the back end's octant counter while
// m_tready is high. A step with no circle loaded gives one word. A two-entry
// job queue lets the front end take words while results stall.
// Reset: synchronous, active low; clears circle state, queue and output.
// ---------------------------------------------------------------------------
// midpoint_circle_generator
// Midpoint circle rasterizer with a command front end, a job queue and a
// pixel back end emitting the eight symmetric points of each step.
// ---------------------------------------------------------------------------
module midpoint_circle_generator #(
    parameter int COORD_BITS  = 12,
    parameter int RADIUS_BITS = 10
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // center_x, center_y, radius, zero padding
    input  wire  [((2*COORD_BITS+RADIUS_BITS+7)/8)*8-1:0] s_tdata,
    // command
    input  wire                                s_tuser,
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // screen_x, screen_y, octant, circle_done
    output logic [31:0]                        m_tdata,
    // pixel_valid
    output logic                               m_tuser,
    output logic                               m_tlast,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [mcg_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire  [COORD_BITS-1:0]              cfg_data
);
    import mcg_pkg::*;

    localparam int IN_BITS  = 2*COORD_BITS + RADIUS_BITS;
    localparam int IN_WIDTH = ((IN_BITS + 7) / 8) * 8;
    localparam int JOB_BITS = JOB_CTRL_BITS + 2*RADIUS_BITS + 2*COORD_BITS;

    logic [COORD_BITS-1:0]   origin_x_reg, origin_x_next;
    logic [COORD_BITS-1:0]   origin_y_reg, origin_y_next;

    logic                    f_push, q_ready, q_valid, q_pop;
    job_ctrl_t               f_ctrl, b_ctrl;
    logic [RADIUS_BITS-1:0]  f_x, f_y, b_x, b_y;
    logic [COORD_BITS-1:0]   f_cx, f_cy, b_cx, b_cy;
    logic [JOB_BITS-1:0]     q_in, q_out;
    logic [SCREEN_BITS-1:0]  r_sx, r_sy;
    logic [OCT_BITS-1:0]     r_oct;
    logic                    r_done;
    logic [IN_WIDTH-1:0]     s_word;

    assign cfg_ready = 1'b1;
    assign s_word    = s_tdata;

    always_comb begin
        origin_x_next = origin_x_reg;
        origin_y_next = origin_y_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_ORIGIN_X: origin_x_next = cfg_data;
                CFG_ORIGIN_Y: origin_y_next = cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= COORD_BITS'(ORIGIN_X_RESET);
            origin_y_reg <= COORD_BITS'(ORIGIN_Y_RESET);
        end else begin
            origin_x_reg <= origin_x_next;
            origin_y_reg <= origin_y_next;
        end
    end

    mcg_front #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (s_tvalid),
        .cmd_ready    (s_tready),
        .cmd_kind     (s_tuser),
        .cmd_center_x (s_word[COORD_BITS-1:0]),
        .cmd_center_y (s_word[2*COORD_BITS-1:COORD_BITS]),
        .cmd_radius   (s_word[IN_BITS-1:2*COORD_BITS]),
        .job_ready    (q_ready),
        .job_push     (f_push),
        .job_ctrl     (f_ctrl),
        .job_x        (f_x),
        .job_y        (f_y),
        .job_center_x (f_cx),
        .job_center_y (f_cy)
    );

    assign q_in = {f_ctrl, f_cy, f_cx, f_y, f_x};
    assign {b_ctrl, b_cy, b_cx, b_y, b_x} = q_out;

    mcg_queue #(
        .WIDTH (JOB_BITS)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (f_push),
        .push_data  (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_out)
    );

    mcg_back #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .origin_x     (origin_x_reg),
        .origin_y     (origin_y_reg),
        .job_valid    (q_valid),
        .job_pop      (q_pop),
        .job_ctrl     (b_ctrl),
        .job_x        (b_x),
        .job_y        (b_y),
        .job_center_x (b_cx),
        .job_center_y (b_cy),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res_pixel    (m_tuser),
        .res_screen_x (r_sx),
        .res_screen_y (r_sy),
        .res_octant   (r_oct),
        .res_last     (m_tlast),
        .res_done     (r_done)
    );

    assign m_tdata = {r_done, r_oct, r_sy, r_sx};

`ifndef SYNTHESIS
    a_invalid_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("word without pixel not marked last");

    a_invalid_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> (m_tdata == 32'd0))
        else $error("word without pixel carries data");

    a_last_octant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tlast == (m_tdata[30:28] == OCT_LAST)))
        else $error("last flag out of step with octant");
`endif

endmodule
`default_nettype wire
